// File: rtl/core/tilemap_window_wrap_slicer_assert.svh
// ----------------------------------------------------------------------------
// tilemap_window_wrap_slicer_assert
// Assertion macros shared by the slicer RTL. Both expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef TILEMAP_WINDOW_WRAP_SLICER_ASSERT_SVH
`define TILEMAP_WINDOW_WRAP_SLICER_ASSERT_SVH

// Same-cycle implication.
`define WWS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("window slicer check failed");

// Next-cycle implication.
`define WWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("window slicer check failed");

`endif

// File: rtl/core/wws_pkg.sv
// ----------------------------------------------------------------------------
// wws_pkg
// Types and constants shared by the tile-map window slicer modules.
// ----------------------------------------------------------------------------
package wws_pkg;

  localparam logic [12:0] MAP_WIDTH_RST  = 13'd64;
  localparam logic [12:0] MAP_HEIGHT_RST = 13'd32;
  localparam logic [12:0] MAP_SIZE_MAX   = 13'd4096;

  // Configuration register indexes.
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  // Remainder unit: 16-bit dividend, two quotient bits per cycle.
  localparam int MOD_RADIX = 2;
  localparam int MOD_STEPS = 16 / MOD_RADIX;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Up to three segments of one axis.
  typedef struct packed {
    logic [1:0]        n;
    logic [2:0][11:0]  map_start;
    logic [2:0][6:0]   plane_start;
    logic [2:0][7:0]   len;
  } axis_t;

  typedef struct packed {
    axis_t ax;
    axis_t ay;
  } win_t;

endpackage

// File: rtl/core/wws_mod.sv
// ----------------------------------------------------------------------------
// wws_mod
// Iterative floor modulo of a signed 16-bit value by a 13-bit divisor.
// ----------------------------------------------------------------------------
module wws_mod import wws_pkg::*; (
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [15:0] value,
  input  logic [12:0] divisor,
  output logic [12:0] result
);

  logic [15:0] mag;
  logic        neg;
  logic [12:0] rem;
  logic [12:0] div;
  logic [15:0] mag_next;
  logic [12:0] rem_next;

  // Restoring remainder, MOD_RADIX dividend bits per cycle.
  always_comb begin
    logic [13:0] t;
    logic [12:0] r;
    logic [15:0] m;
    r = rem;
    m = mag;
    for (int k = 0; k < MOD_RADIX; k++) begin
      t = {r, m[15]};
      m = {m[14:0], 1'b0};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      r = t[12:0];
    end
    rem_next = r;
    mag_next = m;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= value[15];
      mag <= value[15] ? (~value + 16'd1) : value;
      rem <= '0;
      div <= divisor;
    end else if (step) begin
      mag <= mag_next;
      rem <= rem_next;
    end
  end

  // A negative value with a nonzero remainder folds back into range.
  assign result = (neg && rem != 13'd0) ? (div - rem) : rem;

endmodule

// File: rtl/core/wws_queue.sv
// ----------------------------------------------------------------------------
// wws_queue
// Short queue of cut windows between the front and the back.
// ----------------------------------------------------------------------------
module wws_queue import wws_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  win_t  push_data,
  output logic  space,
  output logic  valid,
  output win_t  head,
  input  logic  pop
);

  win_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign space = (count != QCNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/wws_front.sv
// ----------------------------------------------------------------------------
// wws_front
// Takes a window word, reduces its position and cuts both axes into segments.
// ----------------------------------------------------------------------------
module wws_front import wws_pkg::*; #(
  parameter int PLANE_WIDTH  = 64,
  parameter int PLANE_HEIGHT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [12:0]        map_width,
  input  logic [12:0]        map_height,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] view_x,
  input  logic signed [15:0] view_y,
  input  logic [6:0]         view_w,
  input  logic [5:0]         view_h,
  output logic               q_push,
  output win_t               q_data,
  input  logic               q_space
);

  localparam logic [7:0]  PW   = 8'(PLANE_WIDTH);
  localparam logic [7:0]  PH   = 8'(PLANE_HEIGHT);

  // Offsets that make any 16-bit position nonnegative without changing its
  // residue, and reciprocals that are exact for every 17-bit dividend.
  localparam int          POS_OFF_X = ((32768 + PLANE_WIDTH - 1) / PLANE_WIDTH) * PLANE_WIDTH;
  localparam int          POS_OFF_Y = ((32768 + PLANE_HEIGHT - 1) / PLANE_HEIGHT) * PLANE_HEIGHT;
  localparam logic [16:0] OFF_X     = 17'(POS_OFF_X);
  localparam logic [16:0] OFF_Y     = 17'(POS_OFF_Y);
  localparam logic [19:0] RECIP_X   = 20'((1 << 24) / PLANE_WIDTH + 1);
  localparam logic [19:0] RECIP_Y   = 20'((1 << 24) / PLANE_HEIGHT + 1);

  function automatic logic [12:0] clamp_map(input logic [12:0] v);
    if (v == 13'd0) begin
      return 13'd1;
    end else if (v > MAP_SIZE_MAX) begin
      return MAP_SIZE_MAX;
    end
    return v;
  endfunction

  // Cuts one axis where the map wraps and where the plane wraps.
  function automatic axis_t cut_axis(input logic [11:0] mpos, input logic [6:0] ppos,
                                     input logic [7:0] s, input logic [12:0] msize,
                                     input logic [7:0] psize, input logic [11:0] mwrap);
    logic [13:0] mend;
    logic [8:0]  pend;
    logic        cond_m;
    logic        cond_p;
    logic [12:0] cm;
    logic [7:0]  cmn;
    logic [7:0]  cp;
    axis_t       a;
    mend   = {2'b0, mpos} + {6'b0, s};
    cond_m = mend > {1'b0, msize};
    pend   = {2'b0, ppos} + {1'b0, s};
    cond_p = pend > {1'b0, psize};
    cm     = msize - {1'b0, mpos};
    cmn    = cm[7:0];
    cp     = psize - {1'b0, ppos};
    a = '0;
    a.map_start[0]   = mpos;
    a.plane_start[0] = ppos;
    if (cond_m && cond_p && cmn < cp) begin
      a.n              = 2'd3;
      a.len[0]         = cmn;
      a.len[1]         = cp - cmn;
      a.len[2]         = s - cp;
      a.plane_start[1] = 7'({1'b0, ppos} + cmn);
      a.map_start[2]   = mwrap;
    end else if (cond_m && cond_p && cp < cmn) begin
      a.n              = 2'd3;
      a.len[0]         = cp;
      a.len[1]         = cmn - cp;
      a.len[2]         = s - cmn;
      a.map_start[1]   = mpos + {4'b0, cp};
      a.plane_start[2] = 7'(cmn - cp);
    end else if (cond_m && cond_p) begin
      // Both wraps fall on the same tile: one cut.
      a.n      = 2'd2;
      a.len[0] = cp;
      a.len[1] = s - cp;
    end else if (cond_m) begin
      a.n              = 2'd2;
      a.len[0]         = cmn;
      a.len[1]         = s - cmn;
      a.plane_start[1] = 7'({1'b0, ppos} + cmn);
    end else if (cond_p) begin
      a.n            = 2'd2;
      a.len[0]       = cp;
      a.len[1]       = s - cp;
      a.map_start[1] = mpos + {4'b0, cp};
    end else begin
      a.n      = 2'd1;
      a.len[0] = s;
    end
    return a;
  endfunction

  logic                 busy;
  logic                 phase;
  logic [MOD_CNT_W-1:0] cnt;
  logic [7:0]           sx;
  logic [7:0]           sy;
  logic [12:0]          msx;
  logic [12:0]          msy;
  logic [11:0]          mpos_x;
  logic [11:0]          mpos_y;
  logic [12:0]          mx_res;
  logic [12:0]          my_res;
  logic [16:0]          pu_x;
  logic [16:0]          pu_y;
  logic [12:0]          pq_x;
  logic [12:0]          pq_y;
  logic [36:0]          prod_x;
  logic [36:0]          prod_y;
  logic [20:0]          qp_x;
  logic [20:0]          qp_y;
  logic [16:0]          pr_x;
  logic [16:0]          pr_y;
  logic [6:0]           px_res;
  logic [6:0]           py_res;
  logic [12:0]          cm_x;
  logic [12:0]          cm_y;
  logic [7:0]           d_x;
  logic [7:0]           d_y;
  logic                 accept;
  logic                 empty;
  logic                 load1;
  logic                 reload;
  logic                 step_all;
  logic                 finishing;

  assign empty      = (view_w == 7'd0) || (view_h == 6'd0);
  assign accept     = in_valid && in_ready;
  assign load1      = accept && !empty;
  assign step_all   = busy && (cnt != MOD_CNT_W'(MOD_STEPS));
  assign reload     = busy && !phase && (cnt == MOD_CNT_W'(MOD_STEPS));
  assign finishing  = busy && phase && (cnt == MOD_CNT_W'(MOD_STEPS)) && q_space;
  assign in_ready   = !busy || finishing;
  assign q_push     = finishing;

  // Second pass: when the plane cut lies past the map cut, the map start of
  // the third segment is (plane cut - map cut) modulo the map size.
  assign cm_x = msx - {1'b0, mx_res[11:0]};
  assign cm_y = msy - {1'b0, my_res[11:0]};
  assign d_x  = PW - {1'b0, px_res} - cm_x[7:0];
  assign d_y  = PH - {1'b0, py_res} - cm_y[7:0];

  wws_mod u_mod_mx (
    .clk     (clk),
    .load    (load1 || reload),
    .step    (step_all),
    .value   (load1 ? view_x : {8'd0, d_x}),
    .divisor (load1 ? clamp_map(map_width) : msx),
    .result  (mx_res)
  );

  wws_mod u_mod_my (
    .clk     (clk),
    .load    (load1 || reload),
    .step    (step_all),
    .value   (load1 ? view_y : {8'd0, d_y}),
    .divisor (load1 ? clamp_map(map_height) : msy),
    .result  (my_res)
  );

  assign prod_x = {20'd0, pu_x} * {17'd0, RECIP_X};
  assign prod_y = {20'd0, pu_y} * {17'd0, RECIP_Y};
  assign qp_x   = {8'd0, pq_x} * {13'd0, PW};
  assign qp_y   = {8'd0, pq_y} * {13'd0, PH};
  assign pr_x   = pu_x - qp_x[16:0];
  assign pr_y   = pu_y - qp_y[16:0];

  // Plane position: the offset position is divided by a reciprocal multiply;
  // the quotient and then the remainder are registered after the load, long
  // before the remainder is first used.
  always_ff @(posedge clk) begin
    if (load1) begin
      pu_x <= {view_x[15], view_x} + OFF_X;
      pu_y <= {view_y[15], view_y} + OFF_Y;
    end
    pq_x   <= prod_x[36:24];
    pq_y   <= prod_y[36:24];
    px_res <= pr_x[6:0];
    py_res <= pr_y[6:0];
  end

  always_comb begin
    q_data.ax = cut_axis(mpos_x, px_res, sx, msx, PW, mx_res[11:0]);
    q_data.ay = cut_axis(mpos_y, py_res, sy, msy, PH, my_res[11:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else if (load1) begin
      busy  <= 1'b1;
      phase <= 1'b0;
      cnt   <= '0;
    end else if (finishing) begin
      busy <= 1'b0;
    end else if (reload) begin
      phase <= 1'b1;
      cnt   <= '0;
    end else if (step_all) begin
      cnt <= cnt + MOD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      sx  <= ({1'b0, view_w} > PW) ? PW : {1'b0, view_w};
      sy  <= ({2'b0, view_h} > PH) ? PH : {2'b0, view_h};
      msx <= clamp_map(map_width);
      msy <= clamp_map(map_height);
    end
    if (reload) begin
      mpos_x <= mx_res[11:0];
      mpos_y <= my_res[11:0];
    end
  end

endmodule

// File: rtl/core/wws_back.sv
// ----------------------------------------------------------------------------
// wws_back
// Walks the segments of a cut window and emits one rectangle per word.
// ----------------------------------------------------------------------------
module wws_back import wws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  win_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  plane_x,
  output logic [4:0]  plane_y,
  output logic [11:0] map_x,
  output logic [11:0] map_y,
  output logic [6:0]  rect_w,
  output logic [5:0]  rect_h,
  output logic        last
);

  logic [1:0] xi;
  logic [1:0] yi;
  logic       emit;
  logic       x_end;
  logic       last_rect;

  assign emit      = q_valid && (!out_valid || out_ready);
  assign x_end     = (xi == q_head.ax.n - 2'd1);
  assign last_rect = x_end && (yi == q_head.ay.n - 2'd1);
  assign q_pop     = emit && last_rect;

  // Rows outer, columns inner.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      xi        <= '0;
      yi        <= '0;
    end else if (emit) begin
      out_valid <= 1'b1;
      if (last_rect) begin
        xi <= '0;
        yi <= '0;
      end else if (x_end) begin
        xi <= '0;
        yi <= yi + 2'd1;
      end else begin
        xi <= xi + 2'd1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      plane_x <= q_head.ax.plane_start[xi][5:0];
      plane_y <= q_head.ay.plane_start[yi][4:0];
      map_x   <= q_head.ax.map_start[xi];
      map_y   <= q_head.ay.map_start[yi];
      rect_w  <= q_head.ax.len[xi][6:0];
      rect_h  <= q_head.ay.len[yi][5:0];
      last    <= last_rect;
    end
  end

endmodule

// File: rtl/core/tilemap_window_wrap_slicer.sv
// ----------------------------------------------------------------------------
// tilemap_window_wrap_slicer
// Cuts a view window on a wrapping tile map into plane copy rectangles.
// ----------------------------------------------------------------------------
// The front takes a window in a load cycle, steps the two-bit-per-cycle
// remainder units for the map positions (the plane positions come from a
// reciprocal multiply that settles within these steps), reloads them in a
// turnaround cycle, and steps the map remainder units again for the start of
// a segment beyond the second cut; the next window is taken in the cycle the
// current one enters the two-entry queue, and the front waits while the queue
// is full. A window with zero width or height is taken and produces nothing.
// The back emits one rectangle per cycle from the queue while the output is
// ready, rows outer and columns inner, up to nine per window.
module tilemap_window_wrap_slicer import wws_pkg::*; #(
  parameter int PLANE_WIDTH  = 64,
  parameter int PLANE_HEIGHT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] view_x,
  input  logic signed [15:0] view_y,
  input  logic [6:0]         view_w,
  input  logic [5:0]         view_h,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         plane_x,
  output logic [4:0]         plane_y,
  output logic [11:0]        map_x,
  output logic [11:0]        map_y,
  output logic [6:0]         rect_w,
  output logic [5:0]         rect_h,
  output logic               last
);

  `include "tilemap_window_wrap_slicer_assert.svh"

  logic [12:0] map_width;
  logic [12:0] map_height;
  logic        q_push;
  win_t        q_data;
  logic        q_space;
  logic        q_valid;
  win_t        q_head;
  logic        q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_WIDTH_RST;
      map_height <= MAP_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  map_width  <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
      endcase
    end
  end

  wws_front #(
    .PLANE_WIDTH  (PLANE_WIDTH),
    .PLANE_HEIGHT (PLANE_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .map_width  (map_width),
    .map_height (map_height),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .view_x     (view_x),
    .view_y     (view_y),
    .view_w     (view_w),
    .view_h     (view_h),
    .q_push     (q_push),
    .q_data     (q_data),
    .q_space    (q_space)
  );

  wws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .space     (q_space),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  wws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .plane_x   (plane_x),
    .plane_y   (plane_y),
    .map_x     (map_x),
    .map_y     (map_y),
    .rect_w    (rect_w),
    .rect_h    (rect_h),
    .last      (last)
  );

  `WWS_ASSERT_IMPLIES(a_push_has_space, q_push, q_space)
  `WWS_ASSERT_IMPLIES(a_pop_has_word, q_pop, q_valid)
  `WWS_ASSERT_IMPLIES(a_head_nonempty, q_valid, (q_head.ax.n != 2'd0) && (q_head.ay.n != 2'd0))
  `WWS_ASSERT_NEXT(a_push_shows, q_push && !q_valid, q_valid)

endmodule

// File: tb/window_slice_checker.sv
// ----------------------------------------------------------------------------
// window_slice_checker
// Watches the window and rectangle channels of the tile-map window slicer,
// works out the copy rectangles that every accepted window must produce, and
// compares each emitted rectangle field by field with the oldest one due.
// ----------------------------------------------------------------------------
module window_slice_checker import wws_pkg::*; #(
  parameter int PLANE_WIDTH  = 64,
  parameter int PLANE_HEIGHT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] view_x,
  input  logic signed [15:0] view_y,
  input  logic [6:0]         view_w,
  input  logic [5:0]         view_h,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [5:0]         plane_x,
  input  logic [4:0]         plane_y,
  input  logic [11:0]        map_x,
  input  logic [11:0]        map_y,
  input  logic [6:0]         rect_w,
  input  logic [5:0]         rect_h,
  input  logic               last,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [5:0]  plane_x;
    logic [4:0]  plane_y;
    logic [11:0] map_x;
    logic [11:0] map_y;
    logic [6:0]  rect_w;
    logic [5:0]  rect_h;
    logic        last;
  } rect_t;

  // One axis of a window after cutting: up to three segments.
  typedef struct packed {
    logic [1:0]       count;
    logic [2:0][12:0] map_start;
    logic [2:0][12:0] plane_start;
    logic [2:0][7:0]  len;
  } span_set_t;

  logic [12:0] map_w_reg;
  logic [12:0] map_h_reg;
  rect_t       rects_due[$];
  int          fail_count = 0;

  function automatic int eff_map_size(input logic [12:0] v);
    if (v == 13'd0) return 1;
    if (v > MAP_SIZE_MAX) return int'(MAP_SIZE_MAX);
    return int'(v);
  endfunction

  // Floor modulo of a signed tile position.
  function automatic int wrap_pos(input logic signed [15:0] p, input int m);
    int v;
    int r;
    v = p;
    r = v % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic span_set_t split_span(input int mpos, input int ppos, input int s,
                                           input int msize, input int psize);
    int        brk[3];
    int        n;
    int        b;
    span_set_t sp;
    n = 0;
    sp = '0;
    if (mpos + s > msize) begin
      brk[n] = msize - mpos;
      n++;
    end
    if (ppos + s > psize) begin
      b = psize - ppos;
      if (n == 0 || brk[0] < b) begin
        brk[n] = b;
        n++;
      end else if (brk[0] != b) begin
        brk[1] = brk[0];
        brk[0] = b;
        n++;
      end
    end
    // A cut that coincides with the window end is not a cut at all.
    if (n == 0 || brk[n-1] != s) begin
      brk[n] = s;
      n++;
    end
    sp.count = n[1:0];
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        sp.map_start[i]   = mpos[12:0];
        sp.plane_start[i] = ppos[12:0];
        sp.len[i]         = brk[0][7:0];
      end else begin
        sp.map_start[i]   = 13'((mpos + brk[i-1]) % msize);
        sp.plane_start[i] = 13'((ppos + brk[i-1]) % psize);
        sp.len[i]         = 8'(brk[i] - brk[i-1]);
      end
    end
    return sp;
  endfunction

  task automatic flag_mismatch(input string msg);
    fail_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : track
    rect_t     want;
    span_set_t sx;
    span_set_t sy;
    int        mw;
    int        mh;
    int        w;
    int        h;
    int        k;
    int        total;
    if (rst) begin
      map_w_reg <= MAP_WIDTH_RST;
      map_h_reg <= MAP_HEIGHT_RST;
      rects_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (rects_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result word at plane %0d,%0d", plane_x, plane_y));
        end else begin
          want = rects_due.pop_front();
          check_field("plane_x", plane_x, want.plane_x);
          check_field("plane_y", plane_y, want.plane_y);
          check_field("map_x", map_x, want.map_x);
          check_field("map_y", map_y, want.map_y);
          check_field("rect_w", rect_w, want.rect_w);
          check_field("rect_h", rect_h, want.rect_h);
          check_field("last", last, want.last);
        end
      end

      if (in_valid && in_ready) begin
        mw = eff_map_size(map_w_reg);
        mh = eff_map_size(map_h_reg);
        w = (view_w > PLANE_WIDTH) ? PLANE_WIDTH : int'(view_w);
        h = (view_h > PLANE_HEIGHT) ? PLANE_HEIGHT : int'(view_h);
        if (w != 0 && h != 0) begin
          sx = split_span(wrap_pos(view_x, mw), wrap_pos(view_x, PLANE_WIDTH), w, mw,
                          PLANE_WIDTH);
          sy = split_span(wrap_pos(view_y, mh), wrap_pos(view_y, PLANE_HEIGHT), h, mh,
                          PLANE_HEIGHT);
          total = sx.count * sy.count;
          k = 0;
          // Rows outer, columns inner.
          for (int j = 0; j < sy.count; j++) begin
            for (int i = 0; i < sx.count; i++) begin
              want.plane_x = sx.plane_start[i][5:0];
              want.plane_y = sy.plane_start[j][4:0];
              want.map_x   = sx.map_start[i][11:0];
              want.map_y   = sy.map_start[j][11:0];
              want.rect_w  = sx.len[i][6:0];
              want.rect_h  = sy.len[j][5:0];
              want.last    = (k == total - 1);
              rects_due.push_back(want);
              k++;
            end
          end
        end
      end

      if (cfg_we) begin
        if (cfg_index == REG_MAP_WIDTH) map_w_reg <= cfg_data;
        else map_h_reg <= cfg_data;
      end
    end
    pending <= rects_due.size();
    errors <= fail_count;
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives view windows and map size settings into the tile-map window slicer
// with random idling on both channels, and gives the verdict from the count
// of mismatches found by the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import wws_pkg::*;

  localparam int PLANE_W     = 64;
  localparam int PLANE_H     = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_TAIL   = 40;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic               cfg_index;
  logic [12:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] view_x;
  logic signed [15:0] view_y;
  logic [6:0]         view_w;
  logic [5:0]         view_h;
  logic               out_valid;
  logic               out_ready;
  logic [5:0]         plane_x;
  logic [4:0]         plane_y;
  logic [11:0]        map_x;
  logic [11:0]        map_y;
  logic [6:0]         rect_w;
  logic [5:0]         rect_h;
  logic               last;
  int                 errors;
  int                 pending;
  int                 idle_cycles = 0;
  bit                 quiet = 1'b0;

  tilemap_window_wrap_slicer #(
    .PLANE_WIDTH (PLANE_W),
    .PLANE_HEIGHT(PLANE_H)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .view_x   (view_x),
    .view_y   (view_y),
    .view_w   (view_w),
    .view_h   (view_h),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .plane_x  (plane_x),
    .plane_y  (plane_y),
    .map_x    (map_x),
    .map_y    (map_y),
    .rect_w   (rect_w),
    .rect_h   (rect_h),
    .last     (last)
  );

  window_slice_checker #(
    .PLANE_WIDTH (PLANE_W),
    .PLANE_HEIGHT(PLANE_H)
  ) u_check (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .view_x   (view_x),
    .view_y   (view_y),
    .view_w   (view_w),
    .view_h   (view_h),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .plane_x  (plane_x),
    .plane_y  (plane_y),
    .map_x    (map_x),
    .map_y    (map_y),
    .rect_w   (rect_w),
    .rect_h   (rect_h),
    .last     (last),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Positions near zero and near both ends of the 16-bit range hit the
  // wrap points most often.
  function automatic logic signed [15:0] pick_pos();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 600) - 300);
      2: return 16'(32767 - $urandom_range(0, 80));
      default: return 16'($urandom_range(0, 80) - 32768);
    endcase
  endfunction

  function automatic int pick_size(input int plane);
    case ($urandom_range(0, 15))
      0: return 0;
      1: return $urandom_range(plane + 1, 2 * plane - 1);
      2, 3: return plane;
      default: return $urandom_range(1, plane);
    endcase
  endfunction

  task automatic send_window(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic [6:0] w, input logic [5:0] h);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    view_x <= x;
    view_y <= y;
    view_w <= w;
    view_h <= h;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let every due rectangle drain, then give a window with no result time to
  // leave the block.
  task automatic idle_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic set_map_size(input logic [12:0] w, input logic [12:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAP_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_MAP_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Output side: ready in random stretches with stall bursts between them.
  initial begin
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        if (!quiet) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("tilemap_window_wrap_slicer test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int         sent;
    logic [6:0] w;
    logic [5:0] h;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_MAP_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    view_x <= '0;
    view_y <= '0;
    view_w <= '0;
    view_h <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset map size equals the plane size, so map and plane cuts coincide.
    send_window(0, 0, 64, 32);
    send_window(-1, -1, 1, 1);
    send_window(-32768, -32768, 127, 63);
    send_window(32767, 32767, 64, 32);
    send_window(0, 0, 0, 5);
    send_window(3, 3, 5, 0);
    send_window(60, 30, 10, 5);
    send_window(65, 33, 64, 32);
    send_window(-100, 200, 65, 33);
    send_window(16'h5555, 16'hAAAA, 42, 21);

    // Map smaller than the plane: up to three segments per axis.
    idle_block();
    set_map_size(40, 20);
    send_window(30, 15, 40, 25);
    send_window(-10, -5, 64, 32);
    send_window(39, 19, 2, 2);
    send_window(80, 40, 40, 20);

    // Window wider than the map: only the first map wrap cuts.
    idle_block();
    set_map_size(10, 5);
    send_window(0, 0, 64, 32);
    send_window(7, 3, 64, 32);
    send_window(-3, -2, 30, 20);
    send_window(9, 4, 1, 1);

    for (int p = 0; p < 8; p++) begin
      idle_block();
      case (p)
        0: set_map_size(0, 0);
        1: set_map_size(4096, 4096);
        2: set_map_size(8191, 4097);
        3: set_map_size(1, 1);
        4: set_map_size(40, 20);
        5: set_map_size(10, 5);
        6: set_map_size(13'($urandom_range(1, 200)), 13'($urandom_range(1, 100)));
        default: set_map_size(MAP_WIDTH_RST, MAP_HEIGHT_RST);
      endcase
      if (p == 7) quiet = 1'b1;
      sent = 0;
      while (sent < 30) begin
        if (p == 6 && sent == 17) idle_block();
        w = 7'(pick_size(PLANE_W));
        h = 6'(pick_size(PLANE_H));
        send_window(pick_pos(), pick_pos(), w, h);
        if (w != 0 && h != 0) sent++;
      end
    end

    idle_block();
    if (errors == 0) begin
      $display("tilemap_window_wrap_slicer test passed");
    end else begin
      $display("tilemap_window_wrap_slicer test failed");
    end
    $finish;
  end

endmodule
